// ----- design/xterm256_palette_converter_unit_macros.svh -----
// ----------------------------------------------------------------------------
// xterm256 palette converter assertion macros
// shared concurrent assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef XTERM256_PALETTE_CONVERTER_UNIT_MACROS_SVH
`define XTERM256_PALETTE_CONVERTER_UNIT_MACROS_SVH

// implication checked at every clock edge out of reset
`define XPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xpc assertion failed");

// condition that must never hold out of reset
`define XPC_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("xpc assertion failed");

`endif

// ----- design/xpc_pkg.sv -----
// ----------------------------------------------------------------------------
// xpc_pkg
// shared types, constants and helper functions of the palette converter
// ----------------------------------------------------------------------------
package xpc_pkg;

	localparam int NUM_ANSI    = 16;
	localparam int PREP_STAGES = 2;
	localparam int LATENCY     = PREP_STAGES + NUM_ANSI + 1;

	localparam logic [7:0] CUBE_BASE = 8'd16;
	localparam logic [7:0] GRAY_BASE = 8'd232;
	localparam logic [4:0] GRAY_MAX  = 5'd23;
	localparam logic [9:0] GRAY_OFS  = 10'd9;
	// reciprocal of 30 scaled by 2^16, exact for sums up to 765
	localparam logic [21:0] RECIP_30 = 22'd2185;

	localparam logic [7:0] CUBE_LEVEL [6] = '{8'h00, 8'h5f, 8'h87, 8'haf, 8'hd7, 8'hff};

	typedef struct packed {
		logic [2:0] lvl;
		logic [7:0] diff;
	} lvl_t;

	// item travelling down the cell chain
	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] er;
		logic [7:0] eg;
		logic [7:0] eb;
		logic [7:0] cube_idx;
		logic [9:0] cube_d;
		logic [7:0] gray_idx;
		logic [9:0] gray_d;
		logic [3:0] best_idx;
		logic [9:0] best_d;
	} xpc_bus_t;

	function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// rgb of one of the sixteen ansi entries
	function automatic logic [23:0] ansi_rgb(input logic [3:0] e);
		logic [7:0] on_v;
		logic [7:0] off_v;
		on_v  = e[3] ? 8'hff : 8'hc0;
		off_v = e[3] ? 8'h80 : 8'h00;
		return {e[0] ? on_v : off_v, e[1] ? on_v : off_v, e[2] ? on_v : off_v};
	endfunction

	// nearest cube level of one channel, lowest level wins ties
	function automatic lvl_t nearest_level(input logic [7:0] c);
		lvl_t res;
		logic [7:0] d;
		res.lvl  = 3'd0;
		res.diff = c;
		for (int i = 1; i < 6; i++) begin
			d = absdiff(CUBE_LEVEL[i], c);
			if (d < res.diff) begin
				res.diff = d;
				res.lvl  = 3'(i);
			end
		end
		return res;
	endfunction

	// split a cube offset below 216 into base-6 digits
	function automatic logic [8:0] cube_digits(input logic [7:0] k);
		logic [2:0] rd;
		logic [2:0] gd;
		logic [7:0] k1;
		rd = 3'd0;
		for (int j = 1; j < 6; j++) begin
			if (k >= 8'(36 * j)) rd = 3'(j);
		end
		k1 = k - 8'(rd) * 8'd36;
		gd = 3'd0;
		for (int j = 1; j < 6; j++) begin
			if (k1 >= 8'(6 * j)) gd = 3'(j);
		end
		return {rd, gd, 3'(k1 - 8'(gd) * 8'd6)};
	endfunction

	// full expansion of a palette index to rgb
	function automatic logic [23:0] expand(input logic [7:0] idx);
		logic [8:0] dg;
		logic [7:0] v;
		dg = cube_digits(idx - CUBE_BASE);
		v  = (idx - GRAY_BASE) * 8'd10 + 8'd8;
		if (idx < 8'd16) begin
			return ansi_rgb(idx[3:0]);
		end else if (idx < GRAY_BASE) begin
			return {CUBE_LEVEL[dg[8:6]], CUBE_LEVEL[dg[5:3]], CUBE_LEVEL[dg[2:0]]};
		end else begin
			return {v, v, v};
		end
	endfunction

endpackage

// ----- design/xterm256_palette_converter_unit.sv -----
// ----------------------------------------------------------------------------
// xterm256_palette_converter_unit
// 256-color terminal palette expansion and nearest-index matching
// ----------------------------------------------------------------------------
// usage:
// - an item is taken on a rising edge with start high and busy low; busy
//   is always low, so a new item may be started in every cycle
// - kind 0 expands palette_in to red/green/blue_out and echoes the index
// - kind 1 returns the nearest palette index of red/green/blue_in on
//   palette_out by sum of absolute differences, rgb outputs zero
// - each result shows for one cycle with done high, having passed two
//   front-end stages, sixteen ansi search cells and one output register
// - throughput is one item per clock; every cell of the sixteen-cell chain
//   holds one item and passes it on each cycle
// - the receiver cannot stall; results stay in start order
// - reset clears all valid flags, so nothing is in flight afterwards
// ----------------------------------------------------------------------------
module xterm256_palette_converter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       kind,
	input  logic [7:0] palette_in,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	output logic       done,
	output logic [7:0] palette_out,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);

	xpc_pkg::xpc_bus_t chain [xpc_pkg::NUM_ANSI + 1];

	assign busy = 1'b0;

	// front end
	xpc_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start & ~busy),
		.kind       (kind),
		.palette_in (palette_in),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.bus_out    (chain[0])
	);

	// ansi search chain, one entry per cell
	for (genvar i = 0; i < xpc_pkg::NUM_ANSI; i++) begin : g_cell
		xpc_cell #(
			.ENTRY (4'(i))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bus_in  (chain[i]),
			.bus_out (chain[i + 1])
		);
	end

	// result stage
	xpc_final u_final (
		.clk         (clk),
		.arst_n      (arst_n),
		.bus_in      (chain[xpc_pkg::NUM_ANSI]),
		.done        (done),
		.palette_out (palette_out),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out)
	);

endmodule

// ----- design/xpc_prep.sv -----
// ----------------------------------------------------------------------------
// xpc_prep
// two-stage front end: expansion, cube and gray candidates for the chain
// ----------------------------------------------------------------------------
module xpc_prep (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             kind,
	input  logic [7:0]       palette_in,
	input  logic [7:0]       red_in,
	input  logic [7:0]       green_in,
	input  logic [7:0]       blue_in,
	output xpc_pkg::xpc_bus_t bus_out
);

	logic              valid_s1;
	logic              kind_s1;
	logic [7:0]        idx_s1;
	logic [7:0]        r_s1;
	logic [7:0]        g_s1;
	logic [7:0]        b_s1;
	logic [23:0]       exp_s1;
	logic [4:0]        step_s1;
	xpc_pkg::lvl_t     lr_s1;
	xpc_pkg::lvl_t     lg_s1;
	xpc_pkg::lvl_t     lb_s1;
	xpc_pkg::xpc_bus_t bus_s2;

	logic [9:0]  sum;
	logic [9:0]  ofs;
	logic [21:0] prod;
	logic [5:0]  quo;
	logic [4:0]  step;
	logic [7:0]  gray_lvl;

	// gray step: (sum - 9) / 30 by reciprocal, clamped
	assign sum  = {2'b00, red_in} + {2'b00, green_in} + {2'b00, blue_in};
	assign ofs  = (sum < xpc_pkg::GRAY_OFS) ? 10'd0 : (sum - xpc_pkg::GRAY_OFS);
	assign prod = 22'(ofs) * xpc_pkg::RECIP_30;
	assign quo  = prod[21:16];
	assign step = (quo > 6'(xpc_pkg::GRAY_MAX)) ? xpc_pkg::GRAY_MAX : quo[4:0];

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		idx_s1  <= palette_in;
		r_s1    <= red_in;
		g_s1    <= green_in;
		b_s1    <= blue_in;
		exp_s1  <= xpc_pkg::expand(palette_in);
		step_s1 <= step;
		lr_s1   <= xpc_pkg::nearest_level(red_in);
		lg_s1   <= xpc_pkg::nearest_level(green_in);
		lb_s1   <= xpc_pkg::nearest_level(blue_in);
	end

	assign gray_lvl = 8'd8 + 8'(step_s1) * 8'd10;

	// stage 2: candidate indexes and distances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_s2 <= '0;
		end else begin
			bus_s2.valid    <= valid_s1;
			bus_s2.kind     <= kind_s1;
			bus_s2.idx      <= idx_s1;
			bus_s2.r        <= r_s1;
			bus_s2.g        <= g_s1;
			bus_s2.b        <= b_s1;
			bus_s2.er       <= exp_s1[23:16];
			bus_s2.eg       <= exp_s1[15:8];
			bus_s2.eb       <= exp_s1[7:0];
			bus_s2.cube_idx <= 8'(lr_s1.lvl) * 8'd36 + 8'(lg_s1.lvl) * 8'd6
				+ 8'(lb_s1.lvl) + xpc_pkg::CUBE_BASE;
			bus_s2.cube_d   <= {2'b00, lr_s1.diff} + {2'b00, lg_s1.diff}
				+ {2'b00, lb_s1.diff};
			bus_s2.gray_idx <= 8'(step_s1) + xpc_pkg::GRAY_BASE;
			bus_s2.gray_d   <= {2'b00, xpc_pkg::absdiff(gray_lvl, r_s1)}
				+ {2'b00, xpc_pkg::absdiff(gray_lvl, g_s1)}
				+ {2'b00, xpc_pkg::absdiff(gray_lvl, b_s1)};
			bus_s2.best_idx <= 4'd0;
			bus_s2.best_d   <= '1;
		end
	end

	assign bus_out = bus_s2;

endmodule

// ----- design/xpc_cell.sv -----
// ----------------------------------------------------------------------------
// xpc_cell
// one ansi entry of the search chain: keeps the nearer of its entry and the
// best so far, then hands the item on
// ----------------------------------------------------------------------------
module xpc_cell #(
	parameter logic [3:0] ENTRY = 4'd0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  xpc_pkg::xpc_bus_t bus_in,
	output xpc_pkg::xpc_bus_t bus_out
);

	logic [23:0]       ent;
	logic [9:0]        ent_d;
	xpc_pkg::xpc_bus_t nxt;
	xpc_pkg::xpc_bus_t bus_q;

	// distance to this cell's entry
	assign ent   = xpc_pkg::ansi_rgb(ENTRY);
	assign ent_d = {2'b00, xpc_pkg::absdiff(bus_in.r, ent[23:16])}
		+ {2'b00, xpc_pkg::absdiff(bus_in.g, ent[15:8])}
		+ {2'b00, xpc_pkg::absdiff(bus_in.b, ent[7:0])};

	// strictly nearer replaces, so earlier entries win ties
	always_comb begin
		nxt = bus_in;
		if (ent_d < bus_in.best_d) begin
			nxt.best_d   = ent_d;
			nxt.best_idx = ENTRY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q <= '0;
		end else begin
			bus_q <= nxt;
		end
	end

	assign bus_out = bus_q;

endmodule

// ----- design/xpc_final.sv -----
// ----------------------------------------------------------------------------
// xpc_final
// output stage: weighs ansi, cube and gray candidates and drives the result
// ----------------------------------------------------------------------------
module xpc_final (
	input  logic              clk,
	input  logic              arst_n,
	input  xpc_pkg::xpc_bus_t bus_in,
	output logic              done,
	output logic [7:0]        palette_out,
	output logic [7:0]        red_out,
	output logic [7:0]        green_out,
	output logic [7:0]        blue_out
);

	logic [7:0] sel_idx;
	logic [9:0] sel_d;
	logic [7:0] match_idx;

	// candidates in order, later ones only when strictly nearer
	always_comb begin
		sel_idx = {4'd0, bus_in.best_idx};
		sel_d   = bus_in.best_d;
		if (bus_in.cube_d < sel_d) begin
			sel_idx = bus_in.cube_idx;
			sel_d   = bus_in.cube_d;
		end
		match_idx = sel_idx;
		if (bus_in.gray_d < sel_d) begin
			match_idx = bus_in.gray_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done        <= 1'b0;
			palette_out <= '0;
			red_out     <= '0;
			green_out   <= '0;
			blue_out    <= '0;
		end else begin
			done        <= bus_in.valid;
			palette_out <= bus_in.kind ? match_idx : bus_in.idx;
			red_out     <= bus_in.kind ? 8'd0 : bus_in.er;
			green_out   <= bus_in.kind ? 8'd0 : bus_in.eg;
			blue_out    <= bus_in.kind ? 8'd0 : bus_in.eb;
		end
	end

endmodule

// ----- design/xpc_checker.sv -----
// ----------------------------------------------------------------------------
// xpc_checker
// port-level checks of the palette converter, bound to the top level
// ----------------------------------------------------------------------------
`include "xterm256_palette_converter_unit_macros.svh"

module xpc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       kind,
	input logic [7:0] palette_in,
	input logic       done,
	input logic [7:0] palette_out,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out
);

	// every started item comes out with done high
	`XPC_ASSERT_IMP(a_start_done, start && !busy, ##(xpc_pkg::LATENCY) done)
	// no result without a matching start
	`XPC_ASSERT_IMP(a_done_start, done, $past(start && !busy, xpc_pkg::LATENCY))
	// matching results carry zero rgb
	`XPC_ASSERT_IMP(a_match_zero, start && !busy && kind,
		##(xpc_pkg::LATENCY) (red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0))
	// expansion results echo the index
	`XPC_ASSERT_IMP(a_expand_echo, start && !busy && !kind,
		##(xpc_pkg::LATENCY) (palette_out == $past(palette_in, xpc_pkg::LATENCY)))
	// the block never holds items off
	`XPC_ASSERT_NEVER(a_never_busy, busy)

endmodule

bind xterm256_palette_converter_unit xpc_checker u_xpc_checker (.*);
